// ===== sv/qubit_gate_state_update_top_defines.svh =====
// Assertion macros shared by the qubit gate state update block
`ifndef QUBIT_GATE_STATE_UPDATE_TOP_DEFINES_SVH
`define QUBIT_GATE_STATE_UPDATE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define QGSU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("qgsu assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset
`define QGSU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("qgsu assertion failed");

`endif

// ===== sv/qgsu_pkg.sv =====
// Shared types and constants of the qubit gate state update block
package qgsu_pkg;

  localparam int MaxQubitsDef    = 10;
  localparam int FractionBitsDef = 14;
  localparam int DataW    = 16;
  localparam int KindW    = 3;
  localparam int CoefIdxW = 5;
  localparam int AmpIdxW  = 10;
  localparam int QubitW   = 4;
  localparam int CfgW     = 4;
  localparam int StatusW  = 2;

  localparam logic [CfgW-1:0] QubitsReset = 4'd10;

  localparam logic [StatusW-1:0] StatusOk       = 2'd0;
  localparam logic [StatusW-1:0] StatusBadQubit = 2'd1;
  localparam logic [StatusW-1:0] StatusBadIndex = 2'd2;

  typedef enum logic [KindW-1:0] {
    KindLoadCoef = 3'd0,
    KindWriteAmp = 3'd1,
    KindReadAmp  = 3'd2,
    KindGate2    = 3'd3,
    KindGate1    = 3'd4
  } kind_e;

  typedef struct packed {
    logic       load_in;
    logic       mat_wr;
    logic       amp_wr_in;
    logic       rd_in;
    logic       rd_grp;
    logic       cap_vec;
    logic       cap_res;
    logic       mul;
    logic       acc;
    logic       wr_row;
    logic       grp_first;
    logic       grp_next;
    logic [1:0] row;
    logic [1:0] col;
  } cmd_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             idx_bad;
    logic             qubit_bad;
    logic             grp_last;
  } stat_t;

endpackage

// ===== sv/qgsu_in_if.sv =====
// Input item channel
interface qgsu_in_if;
  logic                                valid;
  logic                                ready;
  logic [qgsu_pkg::KindW-1:0]          kind;
  logic [qgsu_pkg::CoefIdxW-1:0]       coef_index;
  logic signed [qgsu_pkg::DataW-1:0]   coef_value;
  logic [qgsu_pkg::AmpIdxW-1:0]        amp_index;
  logic signed [qgsu_pkg::DataW-1:0]   amp_real;
  logic signed [qgsu_pkg::DataW-1:0]   amp_imag;
  logic [qgsu_pkg::QubitW-1:0]         low_qubit;
  logic [qgsu_pkg::QubitW-1:0]         high_qubit;

  modport source (output valid, kind, coef_index, coef_value, amp_index, amp_real, amp_imag,
                  low_qubit, high_qubit, input ready);
  modport sink (input valid, kind, coef_index, coef_value, amp_index, amp_real, amp_imag,
                low_qubit, high_qubit, output ready);
endinterface

// ===== sv/qgsu_out_if.sv =====
// Result item channel
interface qgsu_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [qgsu_pkg::DataW-1:0] read_real;
  logic signed [qgsu_pkg::DataW-1:0] read_imag;
  logic [qgsu_pkg::StatusW-1:0]      status;

  modport source (output valid, read_real, read_imag, status, input ready);
  modport sink (input valid, read_real, read_imag, status, output ready);
endinterface

// ===== sv/qgsu_cfg_if.sv =====
// Configuration write channel
interface qgsu_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [qgsu_pkg::CfgW-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== sv/qubit_gate_state_update_top.sv =====
// Top level of the qubit gate state update block
//
// Holds a 2^MAX_QUBITS state vector of Q2.14 complex amplitudes in a single-port-style
// memory (one write, one registered read per cycle) and a 4x4 complex gate matrix in
// flops that reset clears. Each input transfer yields exactly one result transfer.
// Matrix load, amplitude write and bad-index/bad-qubit items go from decode straight
// to the hand-off state; an amplitude read passes a read-capture state in between. A
// two-qubit gate walks 2^(n-2) groups of four amplitudes, each with four read/capture
// pairs, then four rows of four multiply/accumulate steps plus one write-back. A
// one-qubit gate works on amplitudes 0 and 1 with the same steps over two rows and two
// columns. All work goes through the single amplitude memory port and the one complex
// MAC unit (four 16x16 multipliers, registered, then a rounding accumulate).
// One item is in work at a time; a finished result waits in the output register
// while the next item is taken. The configuration port is always ready and must be
// written only while the block is idle. Amplitudes must be written before they are
// read or gated.
module qubit_gate_state_update_top #(
  parameter int MAX_QUBITS    = qgsu_pkg::MaxQubitsDef,
  parameter int FRACTION_BITS = qgsu_pkg::FractionBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  qgsu_in_if.sink      in_i,
  qgsu_cfg_if.sink     cfg_i,
  qgsu_out_if.source   out_o
);

  `include "qubit_gate_state_update_top_defines.svh"

  qgsu_pkg::cmd_t  cmd;
  qgsu_pkg::stat_t stat;
  logic            out_load;

  // config register is a plain write: no back-pressure
  assign cfg_i.ready = 1'b1;

  qgsu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_load_o  (out_load),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  qgsu_datapath #(
    .MAX_QUBITS    (MAX_QUBITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .kind_i       (in_i.kind),
    .coef_index_i (in_i.coef_index),
    .coef_value_i (in_i.coef_value),
    .amp_index_i  (in_i.amp_index),
    .amp_real_i   (in_i.amp_real),
    .amp_imag_i   (in_i.amp_imag),
    .low_qubit_i  (in_i.low_qubit),
    .high_qubit_i (in_i.high_qubit),
    .cfg_we_i     (cfg_i.valid),
    .cfg_data_i   (cfg_i.data),
    .out_load_i   (out_load),
    .read_real_o  (out_o.read_real),
    .read_imag_o  (out_o.read_imag),
    .status_o     (out_o.status)
  );

  // an accepted item leaves the idle state at once
  `QGSU_ASSERT_NEXT(a_busy_after_transfer, in_i.valid && in_i.ready, !in_i.ready)
  // a new result only appears as the controller returns from its hand-off state
  `QGSU_ASSERT_NOW(a_result_after_work, $rose(out_o.valid), $past(!in_i.ready))
  // memory never sees a read and a write in the same cycle
  `QGSU_ASSERT_NOW(a_mem_one_access, cmd.amp_wr_in || cmd.wr_row, !(cmd.rd_in || cmd.rd_grp))

endmodule

// ===== sv/qgsu_datapath.sv =====
// Datapath: amplitude memory, gate matrix, address generation, complex MAC, result registers
module qgsu_datapath #(
  parameter int MAX_QUBITS    = qgsu_pkg::MaxQubitsDef,
  parameter int FRACTION_BITS = qgsu_pkg::FractionBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  qgsu_pkg::cmd_t                      cmd_i,
  output qgsu_pkg::stat_t                     stat_o,
  input  logic [qgsu_pkg::KindW-1:0]          kind_i,
  input  logic [qgsu_pkg::CoefIdxW-1:0]       coef_index_i,
  input  logic signed [qgsu_pkg::DataW-1:0]   coef_value_i,
  input  logic [qgsu_pkg::AmpIdxW-1:0]        amp_index_i,
  input  logic signed [qgsu_pkg::DataW-1:0]   amp_real_i,
  input  logic signed [qgsu_pkg::DataW-1:0]   amp_imag_i,
  input  logic [qgsu_pkg::QubitW-1:0]         low_qubit_i,
  input  logic [qgsu_pkg::QubitW-1:0]         high_qubit_i,
  input  logic                                cfg_we_i,
  input  logic [qgsu_pkg::CfgW-1:0]           cfg_data_i,
  input  logic                                out_load_i,
  output logic signed [qgsu_pkg::DataW-1:0]   read_real_o,
  output logic signed [qgsu_pkg::DataW-1:0]   read_imag_o,
  output logic [qgsu_pkg::StatusW-1:0]        status_o
);

  localparam int DW    = qgsu_pkg::DataW;
  localparam int AW    = MAX_QUBITS;
  localparam int Depth = 1 << AW;
  localparam int PW    = 2 * DW;
  localparam int AccW  = (PW + 6 - FRACTION_BITS > DW + 1) ? PW + 6 - FRACTION_BITS : DW + 1;
  localparam logic [PW:0] Half = (PW+1)'(1) << (FRACTION_BITS - 1);
  localparam logic signed [AccW-1:0] SatHi = AccW'(32767);
  localparam logic signed [AccW-1:0] SatLo = AccW'(-32768);

  // captured item
  logic [qgsu_pkg::KindW-1:0]    kind_q;
  logic [qgsu_pkg::CoefIdxW-1:0] coef_index_q;
  logic signed [DW-1:0]          coef_value_q;
  logic [qgsu_pkg::AmpIdxW-1:0]  amp_index_q;
  logic signed [DW-1:0]          amp_real_q;
  logic signed [DW-1:0]          amp_imag_q;
  logic [qgsu_pkg::QubitW-1:0]   lo_q;
  logic [qgsu_pkg::QubitW-1:0]   hi_q;

  logic [qgsu_pkg::CfgW-1:0]     qubits_q;
  logic [qgsu_pkg::CfgW-1:0]     n_w;

  logic [AW-1:0]       grp_q;
  logic [AW-1:0]       grp_max;
  logic [AW-1:0]       lb, hb, t_w, base_w;
  logic [AW-1:0]       rd_addr, wr_addr;
  logic [PW-1:0]       wr_data;
  logic                gate1;

  logic [PW-1:0]       mem_q [Depth];
  logic [PW-1:0]       rd_q;

  logic [PW-1:0]       mat_q [16];
  logic [3:0]          ent;
  logic signed [DW-1:0] mr, mi;

  logic signed [DW-1:0] vr_q [4];
  logic signed [DW-1:0] vi_q [4];
  logic signed [PW-1:0] p0_q, p1_q, p2_q, p3_q;
  logic signed [AccW-1:0] acc_re_q, acc_im_q;

  logic signed [DW-1:0] res_re_q, res_im_q;
  logic [qgsu_pkg::StatusW-1:0] status_w;

  function automatic logic signed [AccW-1:0] rnd(input logic signed [PW-1:0] p);
    logic signed [PW:0] s;
    s = {p[PW-1], p} + Half;
    rnd = AccW'(s >>> FRACTION_BITS);
  endfunction

  function automatic logic [DW-1:0] sat(input logic signed [AccW-1:0] a);
    logic [DW-1:0] r;
    if (a > SatHi) begin
      r = {1'b0, {(DW-1){1'b1}}};
    end else if (a < SatLo) begin
      r = {1'b1, {(DW-1){1'b0}}};
    end else begin
      r = a[DW-1:0];
    end
    sat = r;
  endfunction

  function automatic logic [AW-1:0] idx_of(input logic [1:0] sel, input logic [AW-1:0] b,
                                           input logic [AW-1:0] l, input logic [AW-1:0] h);
    idx_of = b | (sel[0] ? l : '0) | (sel[1] ? h : '0);
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      kind_q       <= kind_i;
      coef_index_q <= coef_index_i;
      coef_value_q <= coef_value_i;
      amp_index_q  <= amp_index_i;
      amp_real_q   <= amp_real_i;
      amp_imag_q   <= amp_imag_i;
      lo_q         <= low_qubit_i;
      hi_q         <= high_qubit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qubits_q <= qgsu_pkg::QubitsReset;
    end else if (cfg_we_i) begin
      qubits_q <= cfg_data_i;
    end
  end

  // effective qubit count, clamped to 1..MAX_QUBITS
  always_comb begin
    if (qubits_q == '0) begin
      n_w = qgsu_pkg::CfgW'(1);
    end else if (32'(qubits_q) > MAX_QUBITS) begin
      n_w = qgsu_pkg::CfgW'(MAX_QUBITS);
    end else begin
      n_w = qubits_q;
    end
  end

  assign gate1 = (kind_q == qgsu_pkg::KindGate1);
  assign lb    = gate1 ? AW'(1) : (AW'(1) << lo_q);
  assign hb    = AW'(1) << hi_q;

  // group base: group number with zero bits inserted at the two qubit positions
  assign t_w    = ((grp_q >> lo_q) << ({1'b0, lo_q} + 5'd1)) | (grp_q & (lb - AW'(1)));
  assign base_w = ((t_w >> hi_q) << ({1'b0, hi_q} + 5'd1)) | (t_w & (hb - AW'(1)));
  assign grp_max = (AW'(1) << (n_w - qgsu_pkg::CfgW'(2))) - AW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.grp_first) begin
      grp_q <= '0;
    end else if (cmd_i.grp_next) begin
      grp_q <= grp_q + AW'(1);
    end
  end

  assign stat_o.kind      = kind_q;
  assign stat_o.idx_bad   = (amp_index_q >> n_w) != '0;
  assign stat_o.qubit_bad = !((lo_q < hi_q) && (hi_q < n_w));
  assign stat_o.grp_last  = gate1 || (grp_q == grp_max);

  // amplitude memory
  assign rd_addr = cmd_i.rd_in ? AW'(amp_index_q) : idx_of(cmd_i.col, base_w, lb, hb);
  assign wr_addr = cmd_i.amp_wr_in ? AW'(amp_index_q) : idx_of(cmd_i.row, base_w, lb, hb);
  assign wr_data = cmd_i.amp_wr_in ? {amp_real_q, amp_imag_q}
                                   : {sat(acc_re_q), sat(acc_im_q)};

  always_ff @(posedge clk_i) begin
    if (cmd_i.amp_wr_in || cmd_i.wr_row) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_in || cmd_i.rd_grp) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // gate matrix: 16 complex entries, real in upper half
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        mat_q[i] <= '0;
      end
    end else if (cmd_i.mat_wr) begin
      if (coef_index_q[0]) begin
        mat_q[coef_index_q[4:1]][DW-1:0] <= coef_value_q;
      end else begin
        mat_q[coef_index_q[4:1]][PW-1:DW] <= coef_value_q;
      end
    end
  end

  assign ent = gate1 ? {2'b00, cmd_i.row[0], cmd_i.col[0]} : {cmd_i.row, cmd_i.col};
  assign mr  = mat_q[ent][PW-1:DW];
  assign mi  = mat_q[ent][DW-1:0];

  // vector capture, multiply, accumulate
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_vec) begin
      vr_q[cmd_i.col] <= rd_q[PW-1:DW];
      vi_q[cmd_i.col] <= rd_q[DW-1:0];
    end
    if (cmd_i.mul) begin
      p0_q <= vr_q[cmd_i.col] * mr;
      p1_q <= vi_q[cmd_i.col] * mi;
      p2_q <= vr_q[cmd_i.col] * mi;
      p3_q <= vi_q[cmd_i.col] * mr;
    end
    if (cmd_i.load_in || cmd_i.wr_row) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (cmd_i.acc) begin
      acc_re_q <= acc_re_q + rnd(p0_q) - rnd(p1_q);
      acc_im_q <= acc_im_q + rnd(p2_q) + rnd(p3_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      res_re_q <= '0;
      res_im_q <= '0;
    end else if (cmd_i.cap_res) begin
      res_re_q <= rd_q[PW-1:DW];
      res_im_q <= rd_q[DW-1:0];
    end
  end

  always_comb begin
    unique case (kind_q)
      qgsu_pkg::KindWriteAmp,
      qgsu_pkg::KindReadAmp: status_w = stat_o.idx_bad ? qgsu_pkg::StatusBadIndex
                                                       : qgsu_pkg::StatusOk;
      qgsu_pkg::KindGate2:   status_w = stat_o.qubit_bad ? qgsu_pkg::StatusBadQubit
                                                         : qgsu_pkg::StatusOk;
      default:               status_w = qgsu_pkg::StatusOk;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (out_load_i) begin
      read_real_o <= res_re_q;
      read_imag_o <= res_im_q;
      status_o    <= status_w;
    end
  end

endmodule

// ===== sv/qgsu_ctrl.sv =====
// Controller: sequences item decode, memory reads, MAC steps, write-back and result hand-off
module qgsu_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            out_load_o,
  output qgsu_pkg::cmd_t  cmd_o,
  input  qgsu_pkg::stat_t stat_i
);

  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StDec   = 9'b000000010,
    StRdCap = 9'b000000100,
    StGrd   = 9'b000001000,
    StGcap  = 9'b000010000,
    StMul   = 9'b000100000,
    StAcc   = 9'b001000000,
    StWr    = 9'b010000000,
    StDone  = 9'b100000000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] row_q, row_d, col_q, col_d;
  logic       out_valid_q, out_valid_d;
  logic [1:0] last;

  assign last = (stat_i.kind == qgsu_pkg::KindGate1) ? 2'd1 : 2'd3;

  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_load_o  = 1'b0;
    cmd_o.row   = row_q;
    cmd_o.col   = col_q;

    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = StDec;
        end
      end
      StDec: begin
        state_d = StDone;
        unique case (stat_i.kind)
          qgsu_pkg::KindLoadCoef: cmd_o.mat_wr = 1'b1;
          qgsu_pkg::KindWriteAmp: cmd_o.amp_wr_in = !stat_i.idx_bad;
          qgsu_pkg::KindReadAmp: begin
            if (!stat_i.idx_bad) begin
              cmd_o.rd_in = 1'b1;
              state_d     = StRdCap;
            end
          end
          qgsu_pkg::KindGate2,
          qgsu_pkg::KindGate1: begin
            if (!(stat_i.kind == qgsu_pkg::KindGate2 && stat_i.qubit_bad)) begin
              cmd_o.grp_first = 1'b1;
              col_d           = 2'd0;
              state_d         = StGrd;
            end
          end
          default: state_d = StDone;
        endcase
      end
      StRdCap: begin
        cmd_o.cap_res = 1'b1;
        state_d       = StDone;
      end
      StGrd: begin
        cmd_o.rd_grp = 1'b1;
        state_d      = StGcap;
      end
      StGcap: begin
        cmd_o.cap_vec = 1'b1;
        if (col_q == last) begin
          row_d   = 2'd0;
          col_d   = 2'd0;
          state_d = StMul;
        end else begin
          col_d   = col_q + 2'd1;
          state_d = StGrd;
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StAcc;
      end
      StAcc: begin
        cmd_o.acc = 1'b1;
        if (col_q == last) begin
          state_d = StWr;
        end else begin
          col_d   = col_q + 2'd1;
          state_d = StMul;
        end
      end
      StWr: begin
        cmd_o.wr_row = 1'b1;
        col_d        = 2'd0;
        if (row_q != last) begin
          row_d   = row_q + 2'd1;
          state_d = StMul;
        end else if (stat_i.grp_last) begin
          state_d = StDone;
        end else begin
          cmd_o.grp_next = 1'b1;
          state_d        = StGrd;
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_load_o = 1'b1;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      row_q       <= 2'd0;
      col_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
